>>> hdl/smpc_pkg.sv
// Types, codes and helper functions shared by the signal mask and pending controller.
package smpc_pkg;

	localparam int NumSignals = 32;
	localparam int SigW = $clog2(NumSignals);
	localparam int MaskW = 64;
	localparam logic [MaskW-1:0] Unblockable = (MaskW'(1) << 9) | (MaskW'(1) << 19);
	localparam logic [7:0] ExitBase = 8'd128;
	localparam logic [5:0] SigKill = 6'd9;
	localparam logic [5:0] SigChild = 6'd17;

	typedef enum logic [2:0] {
		KIND_SEND     = 3'd0,
		KIND_BLOCK    = 3'd1,
		KIND_UNBLOCK  = 3'd2,
		KIND_SET_MASK = 3'd3,
		KIND_SET_ACT  = 3'd4,
		KIND_CHECK    = 3'd5,
		KIND_RESTORE  = 3'd6,
		KIND_QUERY    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		DISP_DEFAULT = 2'd0,
		DISP_IGNORE  = 2'd1,
		DISP_HANDLER = 2'd2
	} disp_t;

	typedef enum logic [1:0] {
		ACT_NONE      = 2'd0,
		ACT_DELIVER   = 2'd1,
		ACT_TERMINATE = 2'd2
	} act_t;

	typedef struct packed {
		kind_t            kind;
		logic [5:0]       signal;
		logic [MaskW-1:0] mask;
		logic [1:0]       disposition;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [1:0]       action;
		logic [4:0]       signal_out;
		logic [7:0]       term_code;
		logic [MaskW-1:0] old_mask;
		logic [1:0]       old_disposition;
		logic [MaskW-1:0] old_handler_mask;
	} rsp_t;

	// Signals whose default action terminates the process.
	function automatic logic is_fatal(input logic [5:0] s);
		return (s == 6'd6) || (s == 6'd9) || (s == 6'd11) || (s == 6'd13) || (s == 6'd15);
	endfunction

endpackage

>>> hdl/signal_mask_pending_controller_top.sv
// Signal mask and pending controller: pending set, blocked mask and per-signal actions.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | req_t  (kind, signal, mask, disposition)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_t  (one result beat per request beat)
//
// A request beat is registered, evaluated against the state and written to the result
// register whenever that register is free. One beat is accepted per cycle unless the
// result stalls; the combinational check scan over all signals sets this.
// Reset clears the pending set, the blocked mask, all actions and all handler masks.
// A stalled result holds the evaluation stage, and a held stage holds req_ready low.
module signal_mask_pending_controller_top
	import smpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic                  valid_s1;
	req_t                  item_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic [NumSignals-1:0] pending_q;
	logic [MaskW-1:0]      blocked_q;
	logic [1:0]            disp_q [NumSignals];
	logic [MaskW-1:0]      hmask_q [NumSignals];

	logic                  res_free;
	logic                  fire;
	rsp_t                  res;
	logic [NumSignals-1:0] pending_n;
	logic [MaskW-1:0]      blocked_n;
	logic                  act_wr;
	logic [5:0]            s;
	logic [SigW-1:0]       sidx;
	logic                  s_ok;
	logic [MaskW-1:0]      operand;
	logic [NumSignals-1:0] live;
	logic [NumSignals-1:0] stop;
	logic [NumSignals-1:0] first_oh;
	logic [NumSignals-1:0] clear;
	logic [SigW-1:0]       first_idx;
	logic                  found;
	logic [SigW-1:0]       rd_idx;
	logic [MaskW-1:0]      hmask_rd;

	assign res_free  = !rsp_valid_q || rsp_ready;
	assign fire      = valid_s1 && res_free;
	assign req_ready = !valid_s1 || res_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign s       = item_s1.signal;
	assign sidx    = s[SigW-1:0];
	assign s_ok    = {1'b0, s} < 7'(NumSignals);
	assign operand = item_s1.mask & ~Unblockable;

	assign live = pending_q & ~blocked_q[NumSignals-1:0];

	always_comb begin
		for (int k = 0; k < NumSignals; k++) begin
			stop[k] = (k != 0) && live[k] && ((disp_q[k] == DISP_HANDLER) ||
				((disp_q[k] == DISP_DEFAULT) && is_fatal(6'(k))));
		end
	end

	assign first_oh = stop & (~stop + NumSignals'(1));
	assign found    = |stop;
	assign clear    = found ? (first_oh | (first_oh - NumSignals'(1))) : '1;

	always_comb begin
		first_idx = '0;
		for (int k = 0; k < NumSignals; k++) begin
			if (first_oh[k]) begin
				first_idx = first_idx | SigW'(k);
			end
		end
	end

	assign rd_idx   = (item_s1.kind == KIND_CHECK) ? first_idx : sidx;
	assign hmask_rd = hmask_q[rd_idx];

	always_comb begin
		res       = '0;
		pending_n = pending_q;
		blocked_n = blocked_q;
		act_wr    = 1'b0;
		unique case (item_s1.kind)
			KIND_SEND: begin
				if (!s_ok) begin
					res.status = 1'b1;
				end else if (s != 6'd0) begin
					if (disp_q[sidx] == DISP_DEFAULT) begin
						if (is_fatal(s)) begin
							res.action     = ACT_TERMINATE;
							res.signal_out = s[4:0];
							res.term_code  = ExitBase + 8'(s);
						end
					end else if (disp_q[sidx] != DISP_IGNORE) begin
						pending_n[sidx] = 1'b1;
					end
				end
			end
			KIND_BLOCK, KIND_UNBLOCK, KIND_SET_MASK, KIND_RESTORE: begin
				res.old_mask = blocked_q;
				if (item_s1.kind == KIND_BLOCK) begin
					blocked_n = blocked_q | operand;
				end else if (item_s1.kind == KIND_UNBLOCK) begin
					blocked_n = blocked_q & ~operand;
				end else begin
					blocked_n = operand;
				end
			end
			KIND_SET_ACT, KIND_QUERY: begin
				if (!s_ok || (s == 6'd0) || (s == SigKill)) begin
					res.status = 1'b1;
				end else begin
					res.old_disposition  = disp_q[sidx];
					res.old_handler_mask = hmask_rd;
					if (item_s1.kind == KIND_SET_ACT) begin
						if (item_s1.disposition > DISP_HANDLER) begin
							res.status = 1'b1;
						end else begin
							act_wr = 1'b1;
						end
					end
				end
			end
			KIND_CHECK: begin
				pending_n = pending_q & ~(live & clear);
				if (found) begin
					res.signal_out = 5'(first_idx);
					if (disp_q[first_idx] == DISP_HANDLER) begin
						res.action = ACT_DELIVER;
						blocked_n  = (blocked_q | (MaskW'(1) << first_idx) | hmask_rd)
							& ~Unblockable;
					end else begin
						res.action    = ACT_TERMINATE;
						res.term_code = ExitBase + 8'(first_idx);
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			pending_q   <= '0;
			blocked_q   <= '0;
			for (int k = 0; k < NumSignals; k++) begin
				disp_q[k]  <= DISP_DEFAULT;
				hmask_q[k] <= '0;
			end
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (res_free) begin
				rsp_valid_q <= valid_s1;
			end
			if (fire) begin
				pending_q <= pending_n;
				blocked_q <= blocked_n;
				if (act_wr) begin
					disp_q[sidx]  <= item_s1.disposition;
					hmask_q[sidx] <= item_s1.mask;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (fire) begin
			rsp_q <= res;
		end
	end

endmodule

>>> hdl/smpc_checker.sv
// Port-level checker for the signal mask and pending controller, bound to the top level.
module smpc_props
	import smpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled request beat stays offered and unchanged.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat changed while stalled");

	// A stalled result beat stays presented and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// A rejected request reports no action at all.
	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |->
		rsp.action == ACT_NONE && rsp.signal_out == 5'd0 && rsp.term_code == 8'd0)
		else $error("invalid request reported an action");

	// Termination carries the exit code of its signal.
	a_term_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.action == ACT_TERMINATE |->
		rsp.term_code == ExitBase + 8'(rsp.signal_out) && rsp.signal_out != 5'd0)
		else $error("terminate beat with wrong exit code");

	// Delivery names a real signal and never carries an exit code.
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.action == ACT_DELIVER |->
		rsp.term_code == 8'd0 && rsp.signal_out != 5'd0 && rsp.signal_out != 5'd9)
		else $error("deliver beat malformed");

endmodule

bind signal_mask_pending_controller_top smpc_props u_smpc_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> bench/smpc_checker.sv
// Checker for the signal mask and pending controller: predicts each result beat and compares it.
`timescale 1ns / 1ps

module smpc_checker
	import smpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fails,
	output int   outstanding,
	output int   n_checked,
	output int   n_deliver,
	output int   n_terminate,
	output int   n_invalid
);

	logic [31:0]      pend_bits;
	logic [MaskW-1:0] blk_mask;
	disp_t            disp_tab [NumSignals];
	logic [MaskW-1:0] hmask_tab [NumSignals];
	rsp_t             rsp_due_q [$];

	initial begin
		fails = 0;
		outstanding = 0;
		n_checked = 0;
		n_deliver = 0;
		n_terminate = 0;
		n_invalid = 0;
	end

	function automatic logic kills_by_default(input logic [5:0] s);
		return s == 6'd6 || s == 6'd9 || s == 6'd11 || s == 6'd13 || s == 6'd15;
	endfunction

	task automatic eval_op(input req_t r, output rsp_t o);
		logic [MaskW-1:0] m;
		logic [31:0]      live;
		logic             done;
		logic [4:0]       s;
		o = '0;
		m = r.mask & ~Unblockable;
		s = r.signal[4:0];
		case (r.kind)
			KIND_SEND: begin
				if (r.signal >= NumSignals) begin
					o.status = 1'b1;
				end else if (r.signal != 6'd0) begin
					if (disp_tab[s] == DISP_HANDLER) begin
						pend_bits[s] = 1'b1;
					end else if (disp_tab[s] == DISP_DEFAULT && kills_by_default(r.signal)) begin
						o.action = ACT_TERMINATE;
						o.signal_out = s;
						o.term_code = ExitBase + 8'(s);
					end
				end
			end
			KIND_BLOCK, KIND_UNBLOCK, KIND_SET_MASK, KIND_RESTORE: begin
				o.old_mask = blk_mask;
				if (r.kind == KIND_BLOCK) begin
					blk_mask = blk_mask | m;
				end else if (r.kind == KIND_UNBLOCK) begin
					blk_mask = blk_mask & ~m;
				end else begin
					blk_mask = m;
				end
			end
			KIND_SET_ACT, KIND_QUERY: begin
				if (r.signal == 6'd0 || r.signal >= NumSignals || r.signal == SigKill) begin
					o.status = 1'b1;
				end else begin
					o.old_disposition = disp_tab[s];
					o.old_handler_mask = hmask_tab[s];
					if (r.kind == KIND_SET_ACT) begin
						if (r.disposition > DISP_HANDLER) begin
							o.status = 1'b1;
						end else begin
							disp_tab[s] = disp_t'(r.disposition);
							hmask_tab[s] = r.mask;
						end
					end
				end
			end
			default: begin
				live = pend_bits & ~blk_mask[31:0];
				done = 1'b0;
				for (int k = 1; k < NumSignals; k++) begin
					if (!done && live[k]) begin
						pend_bits[k] = 1'b0;
						if (disp_tab[k] == DISP_HANDLER) begin
							blk_mask = (blk_mask | (MaskW'(1) << k) | hmask_tab[k]) & ~Unblockable;
							o.action = ACT_DELIVER;
							o.signal_out = 5'(k);
							done = 1'b1;
						end else if (disp_tab[k] == DISP_DEFAULT && kills_by_default(6'(k))) begin
							o.action = ACT_TERMINATE;
							o.signal_out = 5'(k);
							o.term_code = ExitBase + 8'(k);
							done = 1'b1;
						end
					end
				end
			end
		endcase
	endtask

	task automatic cmp_field(input string name, input logic [63:0] exp_v, input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t pred;
		if (!arst_n) begin
			pend_bits = '0;
			blk_mask = '0;
			for (int i = 0; i < NumSignals; i++) begin
				disp_tab[i] = DISP_DEFAULT;
				hmask_tab[i] = '0;
			end
			rsp_due_q.delete();
			outstanding = 0;
		end else begin
			if (req_valid && req_ready) begin
				eval_op(req, pred);
				rsp_due_q.push_back(pred);
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp_due_q.size() == 0) begin
					$error("result beat with no request waiting for it");
					fails++;
				end else begin
					want = rsp_due_q.pop_front();
					cmp_field("status", 64'(want.status), 64'(rsp.status));
					cmp_field("action", 64'(want.action), 64'(rsp.action));
					cmp_field("signal_out", 64'(want.signal_out), 64'(rsp.signal_out));
					cmp_field("term_code", 64'(want.term_code), 64'(rsp.term_code));
					cmp_field("old_mask", want.old_mask, rsp.old_mask);
					cmp_field("old_disposition", 64'(want.old_disposition),
						64'(rsp.old_disposition));
					cmp_field("old_handler_mask", want.old_handler_mask, rsp.old_handler_mask);
					n_checked++;
					if (want.action == ACT_DELIVER) n_deliver++;
					if (want.action == ACT_TERMINATE) n_terminate++;
					if (want.status) n_invalid++;
				end
			end
			outstanding = rsp_due_q.size();
		end
	end

endmodule

>>> bench/tb.sv
// Testbench top for the signal mask and pending controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
	import smpc_pkg::*;

	localparam logic [1:0] DispBad = 2'd3;
	localparam int NumRandom = 1250;
	localparam int HoldCycles = 80;
	localparam int WatchLimit = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fails;
	int outstanding;
	int n_checked;
	int n_deliver;
	int n_terminate;
	int n_invalid;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;
	bit hold_rsp = 1'b0;

	always #2 clk = ~clk;

	signal_mask_pending_controller_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	smpc_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fails       (fails),
		.outstanding (outstanding),
		.n_checked   (n_checked),
		.n_deliver   (n_deliver),
		.n_terminate (n_terminate),
		.n_invalid   (n_invalid)
	);

	function automatic req_t mk(input kind_t k, input logic [5:0] s, input logic [63:0] m,
		input logic [1:0] d);
		req_t r;
		r.kind = k;
		r.signal = s;
		r.mask = m;
		r.disposition = d;
		return r;
	endfunction

	function automatic logic [63:0] pick_mask();
		logic [63:0] m;
		int sel;
		m = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			m = m & {$urandom, $urandom} & {$urandom, $urandom};
		end else if (sel == 7) begin
			m = '1;
		end else if (sel == 8) begin
			m = '0;
		end
		return m;
	endfunction

	function automatic req_t rand_op();
		req_t r;
		int sel;
		int ssel;
		ssel = $urandom_range(0, 9);
		if (ssel < 6) begin
			r.signal = 6'($urandom_range(1, 31));
		end else if (ssel == 6) begin
			case ($urandom_range(0, 4))
				0: r.signal = 6'd6;
				1: r.signal = 6'd9;
				2: r.signal = 6'd11;
				3: r.signal = 6'd13;
				default: r.signal = 6'd15;
			endcase
		end else if (ssel == 7) begin
			r.signal = 6'($urandom_range(0, 63));
		end else if (ssel == 8) begin
			r.signal = 6'($urandom_range(1, 8));
		end else begin
			r.signal = ($urandom_range(0, 1) == 0) ? SigChild : 6'd19;
		end
		r.mask = pick_mask();
		if ($urandom_range(0, 15) == 0) begin
			r.disposition = DispBad;
		end else if ($urandom_range(0, 1) == 0) begin
			r.disposition = DISP_HANDLER;
		end else begin
			r.disposition = 2'($urandom_range(0, 2));
		end
		sel = $urandom_range(0, 99);
		if (sel < 30) r.kind = KIND_SEND;
		else if (sel < 55) r.kind = KIND_CHECK;
		else if (sel < 73) r.kind = KIND_SET_ACT;
		else if (sel < 78) r.kind = KIND_QUERY;
		else if (sel < 84) r.kind = KIND_BLOCK;
		else if (sel < 91) r.kind = KIND_UNBLOCK;
		else if (sel < 95) r.kind = KIND_SET_MASK;
		else r.kind = KIND_RESTORE;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is accepted.
	task automatic put(input req_t r);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WatchLimit) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		@(negedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put(mk(KIND_SEND, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, SigKill, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, 6'd6, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, SigChild, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, 6'd1, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, 6'd63, '1, DISP_HANDLER));
		put(mk(KIND_SET_ACT, SigKill, '1, DISP_HANDLER));
		put(mk(KIND_QUERY, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_SET_ACT, 6'd32, '1, DISP_HANDLER));
		put(mk(KIND_SET_ACT, 6'd5, '1, DispBad));
		put(mk(KIND_SET_ACT, 6'd5, '1, DISP_HANDLER));
		put(mk(KIND_SET_ACT, 6'd31, '0, DISP_HANDLER));
		put(mk(KIND_SET_ACT, 6'd11, '0, DISP_HANDLER));
		put(mk(KIND_BLOCK, 6'd0, '1, DISP_DEFAULT));
		put(mk(KIND_SEND, 6'd5, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, 6'd31, '0, DISP_DEFAULT));
		put(mk(KIND_SEND, 6'd11, '0, DISP_DEFAULT));
		put(mk(KIND_CHECK, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_UNBLOCK, 6'd0, '1, DISP_DEFAULT));
		put(mk(KIND_SET_ACT, 6'd11, '0, DISP_DEFAULT));
		put(mk(KIND_CHECK, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_RESTORE, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_CHECK, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_CHECK, 6'd0, '0, DISP_DEFAULT));
		put(mk(KIND_SET_MASK, 6'd0, '1, DISP_DEFAULT));
		put(mk(KIND_QUERY, 6'd5, '0, DISP_DEFAULT));

		for (int i = 0; i < NumRandom; i++) begin
			if (i == 400) begin
				hold_rsp = 1'b1;
			end
			if (i == 800) begin
				req_valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
			end
			if (i == NumRandom - 150) begin
				idle_on = 1'b0;
			end
			put(rand_op());
		end

		req_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(negedge clk);

		$display("Checked %0d result beats: %0d deliveries, %0d terminations, %0d rejected.",
			n_checked, n_deliver, n_terminate, n_invalid);
		$display("Ran all operations with a long result stall and a full drain mid-run.");
		if (fails == 0 && outstanding == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
